FILE: hdl/abfd_pkg.sv
// Package for the ARGB box-filter downscaler: item structs, state and register codes,
// and the widths derived from the frame store and window limits. No dependencies.
package abfd_pkg;

  localparam int MAX_SOURCE_WIDTH  = 256;
  localparam int MAX_SOURCE_HEIGHT = 256;
  localparam int MAX_WINDOW        = 16;

  localparam int COORD_W    = 8;
  localparam int PIXEL_W    = 32;
  localparam int CFG_DIM_W  = 9;
  localparam int CFG_WIN_W  = 5;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_CH     = 4;
  localparam int CH_W       = 8;

  localparam int MAX_DIM   = (MAX_SOURCE_WIDTH > MAX_SOURCE_HEIGHT) ?
                             MAX_SOURCE_WIDTH : MAX_SOURCE_HEIGHT;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int COL_W     = $clog2(MAX_SOURCE_WIDTH);
  localparam int ROW_W     = $clog2(MAX_SOURCE_HEIGHT);
  localparam int DEPTH     = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int DVD_W     = COORD_W + DIM_W;
  localparam int CNT_W     = $clog2(DVD_W);
  localparam int CRD_W     = DVD_W + 2;
  localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W     = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
  localparam int MULB_W    = (SUM_W > DIM_W) ? SUM_W : DIM_W;
  localparam int MUL_W     = GAIN_W + MULB_W;
  localparam int RND_HALF  = 8192;
  localparam int SCALE_SH  = 14;

  localparam logic [CFG_DIM_W-1:0] RST_SOURCE_WIDTH  = 9'd256;
  localparam logic [CFG_DIM_W-1:0] RST_SOURCE_HEIGHT = 9'd256;
  localparam logic [CFG_DIM_W-1:0] RST_OUTPUT_WIDTH  = 9'd128;
  localparam logic [CFG_DIM_W-1:0] RST_OUTPUT_HEIGHT = 9'd128;
  localparam logic [CFG_WIN_W-1:0] RST_WINDOW        = 5'd2;
  localparam logic [GAIN_W-1:0]    RST_GAIN          = 16'd4096;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH,
    REG_SOURCE_HEIGHT,
    REG_OUTPUT_WIDTH,
    REG_OUTPUT_HEIGHT,
    REG_WINDOW_WIDTH,
    REG_WINDOW_HEIGHT,
    REG_GAIN
  } abfd_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_TAPS,
    ST_SCALE,
    ST_DONE
  } abfd_state_t;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIXEL_W-1:0] pixel_in;
  } abfd_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [PIXEL_W-1:0] pixel_out;
  } abfd_out_t;

endpackage

FILE: hdl/abfd_ram.sv
// Generic single-port RAM with one write or read address per cycle and registered read data.
// Used for the frame store of the downscaler. No dependencies.
module abfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: hdl/argb_box_filter_downscaler.sv
// Top level of the ARGB box-filter downscaler: configuration registers, sequencer and datapath.
// Depends on abfd_pkg and instantiates abfd_ram for the frame store.
//
// A write item stores one source pixel if its coordinates lie inside the frame store; busy
// stays low and no result follows. A compute item raises busy until its result strobe,
// which lasts one cycle and cannot be held off, so the receiver must take it then. The
// window registers saturate to MAX_WINDOW, and no taps are read when either is zero. The
// bit-serial coordinate divider runs one quotient bit per cycle for each axis, the frame
// store port delivers one tap per cycle, and one shared multiplier scales the four
// channels in turn. Configuration writes are always ready.
module argb_box_filter_downscaler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  abfd_pkg::abfd_in_t             in_item,
  output logic                           out_valid,
  output abfd_pkg::abfd_out_t            out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [abfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abfd_pkg::CFG_DATA_W-1:0] cfg_data
);

  import abfd_pkg::*;

  abfd_state_t state_r, state_nxt;

  logic [CFG_DIM_W-1:0] src_w_r, src_h_r, out_w_r, out_h_r;
  logic [CFG_WIN_W-1:0] win_w_r, win_h_r;
  logic [GAIN_W-1:0]    gain_r;

  logic [DIM_W-1:0]     sw_eff, sh_eff, sw_m1, sh_m1;
  logic [CFG_DIM_W-1:0] ow_eff, oh_eff, divisor;
  logic [WIN_W-1:0]     ww_eff, wh_eff, ww_m1, wh_m1;

  logic [COORD_W-1:0]   x_r, y_r;
  logic                 dim_sel_r;
  logic [GAIN_W-1:0]    mul_a;
  logic [MULB_W-1:0]    mul_b;
  logic [MUL_W-1:0]     mul_r;

  logic [CFG_DIM_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [CFG_DIM_W:0]   rem_sh, diff;
  logic [CNT_W-1:0]     bit_cnt_r;
  logic                 div_last;
  logic signed [CRD_W-1:0] base_nxt, ubase_r, vbase_r, tap_u, tap_v;

  logic                 issue_r, v0_r, v1_r;
  logic [WIN_W-1:0]     a_r, b_r;
  logic [COL_W-1:0]     cu, cu_r;
  logic [ROW_W-1:0]     cv, cv_r;
  logic                 taps_done, win_empty;
  logic [SUM_W-1:0]     sum_r [NUM_CH];

  logic [2:0]           ch_r;
  logic [1:0]           ch_prev;
  logic [MUL_W:0]       rnd, scaled;
  logic [CH_W-1:0]      sat_byte;
  logic [PIXEL_W-1:0]   res_r;

  logic                 accept, accept_wr, accept_cmp, wr_in_range;
  logic [ADDR_W-1:0]    wr_addr, rd_addr, ram_addr;
  logic [PIXEL_W-1:0]   ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= RST_SOURCE_WIDTH;
      src_h_r <= RST_SOURCE_HEIGHT;
      out_w_r <= RST_OUTPUT_WIDTH;
      out_h_r <= RST_OUTPUT_HEIGHT;
      win_w_r <= RST_WINDOW;
      win_h_r <= RST_WINDOW;
      gain_r  <= RST_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  src_w_r <= cfg_data[CFG_DIM_W-1:0];
        REG_SOURCE_HEIGHT: src_h_r <= cfg_data[CFG_DIM_W-1:0];
        REG_OUTPUT_WIDTH:  out_w_r <= cfg_data[CFG_DIM_W-1:0];
        REG_OUTPUT_HEIGHT: out_h_r <= cfg_data[CFG_DIM_W-1:0];
        REG_WINDOW_WIDTH:  win_w_r <= cfg_data[CFG_WIN_W-1:0];
        REG_WINDOW_HEIGHT: win_h_r <= cfg_data[CFG_WIN_W-1:0];
        REG_GAIN:          gain_r  <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (src_w_r == '0) begin
      sw_eff = DIM_W'(1);
    end else if (32'(src_w_r) > MAX_SOURCE_WIDTH) begin
      sw_eff = DIM_W'(MAX_SOURCE_WIDTH);
    end else begin
      sw_eff = DIM_W'(src_w_r);
    end
    if (src_h_r == '0) begin
      sh_eff = DIM_W'(1);
    end else if (32'(src_h_r) > MAX_SOURCE_HEIGHT) begin
      sh_eff = DIM_W'(MAX_SOURCE_HEIGHT);
    end else begin
      sh_eff = DIM_W'(src_h_r);
    end
    ow_eff = (out_w_r == '0) ? CFG_DIM_W'(1) : out_w_r;
    oh_eff = (out_h_r == '0) ? CFG_DIM_W'(1) : out_h_r;
    ww_eff = (32'(win_w_r) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : WIN_W'(win_w_r);
    wh_eff = (32'(win_h_r) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : WIN_W'(win_h_r);
    sw_m1  = sw_eff - DIM_W'(1);
    sh_m1  = sh_eff - DIM_W'(1);
    ww_m1  = ww_eff - WIN_W'(1);
    wh_m1  = wh_eff - WIN_W'(1);
    win_empty = (ww_eff == '0) || (wh_eff == '0);
  end

  assign accept      = start && !busy;
  assign accept_wr   = accept && (in_item.op == OP_WRITE) && wr_in_range;
  assign accept_cmp  = accept && (in_item.op == OP_COMPUTE);
  assign wr_in_range = (32'(in_item.x) < MAX_SOURCE_WIDTH) &&
                       (32'(in_item.y) < MAX_SOURCE_HEIGHT);
  assign wr_addr     = ADDR_W'(32'(in_item.y) * MAX_SOURCE_WIDTH + 32'(in_item.x));
  assign rd_addr     = ADDR_W'(32'(cv_r) * MAX_SOURCE_WIDTH + 32'(cu_r));
  assign ram_addr    = (state_r == ST_IDLE) ? wr_addr : rd_addr;

  abfd_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (accept_wr),
    .addr  (ram_addr),
    .wdata (in_item.pixel_in),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (state_r == ST_SCALE) begin
      mul_a = gain_r;
      mul_b = MULB_W'(sum_r[ch_r[1:0]]);
    end else if (!dim_sel_r) begin
      mul_a = GAIN_W'(x_r);
      mul_b = MULB_W'(sw_eff);
    end else begin
      mul_a = GAIN_W'(y_r);
      mul_b = MULB_W'(sh_eff);
    end
  end

  always_comb begin
    divisor  = dim_sel_r ? oh_eff : ow_eff;
    rem_sh   = {rem_r, quo_r[DVD_W-1]};
    diff     = rem_sh - {1'b0, divisor};
    if (!diff[CFG_DIM_W]) begin
      rem_nxt = diff[CFG_DIM_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[CFG_DIM_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
    end
    div_last = (bit_cnt_r == CNT_W'(DVD_W - 1));
    base_nxt = $signed(CRD_W'(quo_nxt)) + $signed(CRD_W'(1))
             - $signed(CRD_W'(dim_sel_r ? (wh_eff >> 1) : (ww_eff >> 1)));
  end

  always_comb begin
    tap_u = ubase_r + $signed(CRD_W'(a_r));
    tap_v = vbase_r + $signed(CRD_W'(b_r));
    if (tap_u < 0) begin
      cu = '0;
    end else if (tap_u > $signed(CRD_W'(sw_m1))) begin
      cu = COL_W'(sw_m1);
    end else begin
      cu = COL_W'(tap_u);
    end
    if (tap_v < 0) begin
      cv = '0;
    end else if (tap_v > $signed(CRD_W'(sh_m1))) begin
      cv = ROW_W'(sh_m1);
    end else begin
      cv = ROW_W'(tap_v);
    end
    taps_done = !issue_r && !v0_r && !v1_r;
  end

  always_comb begin
    ch_prev  = ch_r[1:0] - 2'd1;
    rnd      = (MUL_W + 1)'(mul_r) + (MUL_W + 1)'(RND_HALF);
    scaled   = rnd >> SCALE_SH;
    sat_byte = (scaled > (MUL_W + 1)'(255)) ? {CH_W{1'b1}} : scaled[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept_cmp) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          if (!dim_sel_r) begin
            state_nxt = ST_MUL;
          end else if (win_empty) begin
            state_nxt = ST_SCALE;
          end else begin
            state_nxt = ST_TAPS;
          end
        end
      end
      ST_TAPS: begin
        if (taps_done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (ch_r == 3'(NUM_CH)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
    end else if (state_r == ST_DIV && div_last && dim_sel_r) begin
      issue_r <= !win_empty;
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
    end else if (state_r == ST_TAPS) begin
      v0_r <= issue_r;
      v1_r <= v0_r;
      if (issue_r && b_r == wh_m1 && a_r == ww_m1) begin
        issue_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept_cmp) begin
          x_r       <= in_item.x;
          y_r       <= in_item.y;
          dim_sel_r <= 1'b0;
        end
      end
      ST_MUL: mul_r <= MUL_W'(mul_a * mul_b);
      ST_LOAD: begin
        rem_r     <= '0;
        quo_r     <= mul_r[DVD_W-1:0];
        bit_cnt_r <= '0;
      end
      ST_DIV: begin
        rem_r     <= rem_nxt;
        quo_r     <= quo_nxt;
        bit_cnt_r <= bit_cnt_r + CNT_W'(1);
        if (div_last) begin
          if (!dim_sel_r) begin
            ubase_r   <= base_nxt;
            dim_sel_r <= 1'b1;
          end else begin
            vbase_r <= base_nxt;
            a_r     <= '0;
            b_r     <= '0;
            ch_r    <= '0;
            for (int k = 0; k < NUM_CH; k++) begin
              sum_r[k] <= '0;
            end
          end
        end
      end
      ST_TAPS: begin
        if (issue_r) begin
          cu_r <= cu;
          cv_r <= cv;
          if (b_r == wh_m1) begin
            b_r <= '0;
            a_r <= a_r + WIN_W'(1);
          end else begin
            b_r <= b_r + WIN_W'(1);
          end
        end
        if (v1_r) begin
          for (int k = 0; k < NUM_CH; k++) begin
            sum_r[k] <= sum_r[k] + SUM_W'(ram_rdata[k*CH_W +: CH_W]);
          end
        end
      end
      ST_SCALE: begin
        mul_r <= MUL_W'(mul_a * mul_b);
        if (ch_r != '0) begin
          res_r[ch_prev*CH_W +: CH_W] <= sat_byte;
        end
        ch_r <= ch_r + 3'd1;
      end
      default: begin
      end
    endcase
  end

  assign out_item.out_x     = x_r;
  assign out_item.out_y     = y_r;
  assign out_item.pixel_out = res_r;

endmodule
